/* sv/psgm_pkg.sv */
// package: sizes, status codes, register indexes and sequencer states
package psgm_pkg;
    localparam int MAX_BANDS   = 64;
    localparam int NUM_RADIOS  = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_W      = $clog2(MAX_BANDS);
    localparam int RADIO_W     = $clog2(NUM_RADIOS);
    localparam int IDX_W       = SLOT_W + RADIO_W;
    localparam int USED_W      = $clog2(MAX_BANDS + 1);
    localparam int ADDR_W      = 40;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BAND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TX_MODE       = 2'd2;

    localparam logic [2:0] ST_ZERO_ADDR  = 3'd0;
    localparam logic [2:0] ST_FILTERED   = 3'd1;
    localparam logic [2:0] ST_BAD_RADIO  = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_IN_ORDER   = 3'd4;
    localparam logic [2:0] ST_GAP        = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_CLEAR, S_RD, S_RDW, S_UPD, S_WR, S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]  radio_index;
        logic [ADDR_W-1:0] sender_addr;
        logic [7:0]  band_seq;
        logic [7:0]  loopback_byte;
        logic [7:0]  receiver_seq;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  band_slot;
        logic        new_band;
        logic [5:0]  missing;
        logic        rcv_seq_error;
        logic [31:0] radio_good_count;
        logic [31:0] radio_bad_count;
        logic [31:0] band_bad_count;
        logic [31:0] total_packets;
        logic [31:0] total_bad_seq;
        logic [31:0] total_bad_rcv_seq;
        logic [31:0] total_loopback;
    } out_t;
endpackage

/* sv/psgm_if.sv */
// valid/ready channel interface carrying one payload
interface psgm_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/per_band_sequence_gap_monitor.sv */
// top level: configuration registers and the gap monitor sequencer
// a request is screened in S_SEARCH, then searches the band table through S_RD and S_RDW per entry
// before S_CLEAR, S_UPD, S_WR and S_OUT; a new band also clears its radio entries in S_CLEAR
// one message at a time: the next request is taken the cycle after the result is accepted
// reset clears registers, band count, receiver sequences and global counters at once
// band table entries are cleared on insert, so no clearing pass after reset
module per_band_sequence_gap_monitor
    import psgm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    psgm_if.sink   in_ch,
    psgm_if.source out_ch
);
    logic filter_enable_reg, tx_mode_reg;
    logic [ADDR_W-1:0] filter_band_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            filter_band_reg   <= '0;
            tx_mode_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                REG_FILTER_BAND:   filter_band_reg   <= cfg_data;
                REG_TX_MODE:       tx_mode_reg       <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    psgm_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .filter_enable (filter_enable_reg),
        .filter_band   (filter_band_reg),
        .tx_mode       (tx_mode_reg),
        .in_valid      (in_ch.valid),
        .in_ready      (in_ch.ready),
        .in_data       (in_ch.data),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_data      (out_ch.data)
    );
endmodule

/* sv/psgm_core.sv */
// sequencer over the band table and counter memories
module psgm_core
    import psgm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic filter_enable,
    input  logic [ADDR_W-1:0] filter_band,
    input  logic tx_mode,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);
    // memories
    logic [ADDR_W-1:0]      ids_mem [MAX_BANDS];
    logic [8:0]             seq_mem [MAX_BANDS*NUM_RADIOS];
    logic [COUNT_WIDTH-1:0] good_mem [MAX_BANDS*NUM_RADIOS];
    logic [COUNT_WIDTH-1:0] bad_mem [MAX_BANDS*NUM_RADIOS];
    logic [COUNT_WIDTH-1:0] tot_mem [MAX_BANDS];

    state_t state_reg, state_next;
    in_t    item_reg, item_next;
    out_t   res_reg, res_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [USED_W-1:0] ptr_reg, ptr_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [RADIO_W:0]  clr_reg, clr_next;
    logic new_reg, new_next;
    logic [8:0] rseq_reg [NUM_RADIOS];
    logic [COUNT_WIDTH-1:0] g_pkt_reg, g_pkt_next, g_seq_reg, g_seq_next;
    logic [COUNT_WIDTH-1:0] g_rcv_reg, g_rcv_next, g_loop_reg, g_loop_next;
    logic [8:0] seq_rd_reg;
    logic [COUNT_WIDTH-1:0] good_rd_reg, bad_rd_reg, tot_rd_reg;
    logic [ADDR_W-1:0] id_rd_reg;
    logic [COUNT_WIDTH-1:0] good_wr_reg, good_wr_next, bad_wr_reg, bad_wr_next;
    logic [COUNT_WIDTH-1:0] tot_wr_reg, tot_wr_next;

    logic [RADIO_W-1:0] radio;
    logic [IDX_W-1:0]   idx, clr_idx;
    logic [7:0] diff;
    logic [5:0] miss;
    logic gap, rerr;
    logic rs_wr, ids_wr, clr_wr, cnt_wr;

    assign radio   = item_reg.radio_index[RADIO_W-1:0];
    assign idx     = {slot_reg, radio};
    assign clr_idx = {slot_reg, clr_reg[RADIO_W-1:0]};
    assign diff    = item_reg.band_seq - seq_rd_reg[7:0];
    assign miss    = (diff >= 8'd4) ? 6'(diff[7:2] - 6'd1) : 6'd0;
    assign gap     = seq_rd_reg[8] && (item_reg.band_seq != seq_rd_reg[7:0] + 8'd4);
    assign rerr    = rseq_reg[radio][8] &&
                     (item_reg.receiver_seq != rseq_reg[radio][7:0] + 8'd1);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            g_pkt_reg  <= '0;
            g_seq_reg  <= '0;
            g_rcv_reg  <= '0;
            g_loop_reg <= '0;
            for (int r = 0; r < NUM_RADIOS; r++)
            begin
                rseq_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            g_pkt_reg  <= g_pkt_next;
            g_seq_reg  <= g_seq_next;
            g_rcv_reg  <= g_rcv_next;
            g_loop_reg <= g_loop_next;
            if (rs_wr)
            begin
                rseq_reg[radio] <= {1'b1, item_reg.receiver_seq};
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        ptr_reg     <= ptr_next;
        slot_reg    <= slot_next;
        clr_reg     <= clr_next;
        new_reg     <= new_next;
        good_wr_reg <= good_wr_next;
        bad_wr_reg  <= bad_wr_next;
        tot_wr_reg  <= tot_wr_next;
    end

    // memories
    always_ff @(posedge clk)
    begin
        id_rd_reg   <= ids_mem[ptr_reg[SLOT_W-1:0]];
        seq_rd_reg  <= seq_mem[idx];
        good_rd_reg <= good_mem[idx];
        bad_rd_reg  <= bad_mem[idx];
        tot_rd_reg  <= tot_mem[slot_reg];
        if (ids_wr)
        begin
            ids_mem[slot_reg] <= item_reg.sender_addr;
            tot_mem[slot_reg] <= '0;
        end
        if (clr_wr)
        begin
            seq_mem[clr_idx]  <= '0;
            good_mem[clr_idx] <= '0;
            bad_mem[clr_idx]  <= '0;
        end
        if (cnt_wr)
        begin
            seq_mem[idx]   <= {1'b1, item_reg.band_seq};
            good_mem[idx]  <= good_wr_reg;
            bad_mem[idx]   <= bad_wr_reg;
            tot_mem[slot_reg] <= tot_wr_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        used_next    = used_reg;
        ptr_next     = ptr_reg;
        slot_next    = slot_reg;
        clr_next     = clr_reg;
        new_next     = new_reg;
        good_wr_next = good_wr_reg;
        bad_wr_next  = bad_wr_reg;
        tot_wr_next  = tot_wr_reg;
        g_pkt_next   = g_pkt_reg;
        g_seq_next   = g_seq_reg;
        g_rcv_next   = g_rcv_reg;
        g_loop_next  = g_loop_reg;
        rs_wr  = 1'b0;
        ids_wr = 1'b0;
        clr_wr = 1'b0;
        cnt_wr = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_next = in_data;
                ptr_next  = '0;
                slot_next = '0;
                new_next  = 1'b0;
                if (in_valid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // screening, then on to the table search in S_RD and S_RDW
                res_next = '0;
                if (item_reg.sender_addr == '0)
                begin
                    res_next.status = ST_ZERO_ADDR;
                    state_next = S_OUT;
                end
                else if (filter_enable && item_reg.sender_addr != filter_band)
                begin
                    rs_wr = (item_reg.radio_index < 8'(NUM_RADIOS));
                    res_next.status = ST_FILTERED;
                    state_next = S_OUT;
                end
                else
                begin
                    if (item_reg.loopback_byte != '0)
                    begin
                        g_loop_next = g_loop_reg + 1'b1;
                    end
                    if (item_reg.radio_index >= 8'(NUM_RADIOS))
                    begin
                        res_next.status = ST_BAD_RADIO;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD;
                        clr_next   = '0;
                    end
                end
            end
            S_RD:
            begin
                // id memory read of ptr is in flight
                if (ptr_reg >= used_reg)
                begin
                    if (used_reg >= USED_W'(MAX_BANDS))
                    begin
                        res_next = '0;
                        res_next.status = ST_TABLE_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        slot_next = used_reg[SLOT_W-1:0];
                        used_next = used_reg + 1'b1;
                        new_next  = 1'b1;
                        clr_next  = '0;
                        if (tx_mode && item_reg.loopback_byte == '0)
                        begin
                            g_loop_next = g_loop_reg + 1'b1;
                        end
                        state_next = S_CLEAR;
                    end
                end
                else
                begin
                    state_next = S_RDW;
                end
            end
            S_RDW:
            begin
                if (id_rd_reg == item_reg.sender_addr)
                begin
                    slot_next  = ptr_reg[SLOT_W-1:0];
                    clr_next   = (RADIO_W+1)'(NUM_RADIOS);
                    state_next = S_CLEAR;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_CLEAR:
            begin
                // clear one radio entry per cycle of a new band, then read
                if (clr_reg == (RADIO_W+1)'(NUM_RADIOS))
                begin
                    clr_next   = '0;
                    state_next = S_UPD;
                end
                else
                begin
                    ids_wr   = new_reg && (clr_reg == '0);
                    clr_wr   = new_reg;
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_UPD:
            begin
                // wait for counter reads, then form new values
                if (clr_reg == '0)
                begin
                    clr_next = (RADIO_W+1)'(1);
                end
                else
                begin
                    good_wr_next = good_rd_reg + COUNT_WIDTH'(!gap);
                    bad_wr_next  = bad_rd_reg + (gap ? COUNT_WIDTH'(miss) : '0);
                    tot_wr_next  = tot_rd_reg + (gap ? COUNT_WIDTH'(miss) : '0);
                    if (gap)
                    begin
                        g_seq_next = g_seq_reg + 1'b1;
                    end
                    if (rerr)
                    begin
                        g_rcv_next = g_rcv_reg + 1'b1;
                    end
                    g_pkt_next = g_pkt_reg + 1'b1;
                    res_next = '0;
                    res_next.status        = gap ? ST_GAP : ST_IN_ORDER;
                    res_next.band_slot     = 6'(slot_reg);
                    res_next.new_band      = new_reg;
                    res_next.missing       = gap ? miss : 6'd0;
                    res_next.rcv_seq_error = rerr;
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cnt_wr = 1'b1;
                rs_wr  = 1'b1;
                res_next.radio_good_count = good_wr_reg[31:0];
                res_next.radio_bad_count  = bad_wr_reg[31:0];
                res_next.band_bad_count   = tot_wr_reg[31:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg != S_OUT)
        begin
            res_next.total_packets     = g_pkt_next[31:0];
            res_next.total_bad_seq     = g_seq_next[31:0];
            res_next.total_bad_rcv_seq = g_rcv_next[31:0];
            res_next.total_loopback    = g_loop_next[31:0];
        end
    end
endmodule

/* sv/psgm_checker.sv */
// port-level checker for the gap monitor, bound to the top level
module psgm_checker
    import psgm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);
    // never ready for a request while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input ready while result pending");
    // accepted request does not yield a result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result too early");
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed under stall");
    // per-band fields are zero for untracked messages
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status <= ST_TABLE_FULL) |->
        (out_data.band_slot == 0 && out_data.missing == 0 && !out_data.new_band))
        else $error("per-band fields set for untracked message");
endmodule

bind per_band_sequence_gap_monitor psgm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
